// ===== design/ucs_pkg.sv =====
package ucs_pkg;

  localparam int unsigned MAX_CHILDREN_DEF = 64;
  localparam logic [23:0] EXPL_RESET = 24'd92682;

  // ln(2) in Q.56, the scale of the series sum after its final shift.
  localparam logic [63:0] LN2_Q56 = 64'hB17217F7D1CF79AB >> 8;

  localparam int unsigned SERIES_TERMS = 40;
  localparam int unsigned MUL_STEPS = 62;
  localparam int unsigned SQRT_STEPS = 20;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOGNORM,
    ST_TDIV,
    ST_T2MUL,
    ST_SLAUNCH,
    ST_SDIV,
    ST_SMUL,
    ST_LNFIN,
    ST_LNSUM,
    ST_ELAUNCH,
    ST_EDIV,
    ST_QDIV,
    ST_SQRT,
    ST_XMUL,
    ST_SCORE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic        start;
    logic [6:0]  count;
    logic [25:0] rem_init;
    logic [25:0] divisor;
    logic [63:0] dividend;
  } div_req_t;

endpackage

// ===== design/ucs_div.sv =====
module ucs_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ucs_pkg::div_req_t req_i,
  output logic              done_o,
  output logic [63:0]       quot_o
);
  import ucs_pkg::*;

  logic        active_q;
  logic        done_q;
  logic [6:0]  cnt_q;
  logic [25:0] rem_q;
  logic [25:0] dsr_q;
  logic [63:0] dvd_q;
  logic [63:0] quot_q;
  logic [26:0] rem_sh;
  logic [26:0] rem_sub;
  logic        ge;
  logic [25:0] rem_d;

  assign rem_sh  = {rem_q, dvd_q[63]};
  assign rem_sub = rem_sh - {1'b0, dsr_q};
  assign ge      = rem_sh >= {1'b0, dsr_q};
  assign rem_d   = ge ? rem_sub[25:0] : rem_sh[25:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else if (req_i.start) begin
      active_q <= 1'b1;
      done_q   <= 1'b0;
      cnt_q    <= req_i.count;
    end else if (active_q) begin
      cnt_q <= cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        active_q <= 1'b0;
        done_q   <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.rem_init;
      dsr_q  <= req_i.divisor;
      dvd_q  <= req_i.dividend;
      quot_q <= '0;
    end else if (active_q) begin
      rem_q  <= rem_d;
      dvd_q  <= {dvd_q[62:0], 1'b0};
      quot_q <= {quot_q[62:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== design/uct_child_select.sv =====
// UCT child selection. Pulse start_i with one child per transaction while
// busy_o is low; the parent visit count is taken from the first child of a
// set. Each child runs 40-step and 24-step serial divisions, a 20-step
// square root and a scoring step; the first child of a set also evaluates
// ln(P+1) through a 62-step division and 40 series terms, each a 64-step
// division, with a 62-step serial multiply after all terms but the last.
// After the child marked last, valid_o is high for one cycle with the index
// and score of the first best child and the overflow flag; the receiver
// cannot stall it and must take it then. Children past MaxChildren skip
// scoring and set the overflow flag; one marked last still ends the set.
module uct_child_select #(
  parameter int unsigned MaxChildren = ucs_pkg::MAX_CHILDREN_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [23:0] cfg_wdata_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [23:0] parent_visits_i,
  input  logic [23:0] child_wins_i,
  input  logic [23:0] child_visits_i,
  input  logic        last_child_i,
  output logic        valid_o,
  output logic [5:0]  best_index_o,
  output logic [39:0] best_score_o,
  output logic        overflow_o
);
  import ucs_pkg::*;

  localparam int unsigned CW = $clog2(MaxChildren + 1);

  state_e state_q, state_d;

  logic [23:0]   c_q;
  logic [23:0]   pv_q;
  logic [23:0]   wins_q;
  logic [24:0]   v1_q;
  logic          last_q;
  logic [CW-1:0] cnt_q;
  logic [39:0]   best_score_q;
  logic [5:0]    best_idx_q;
  logic          ovf_q;
  logic [23:0]   log_q;
  logic [24:0]   xn_q;
  logic [4:0]    k_q;
  logic [61:0]   t2_q;
  logic [61:0]   pw_q;
  logic [63:0]   sum_q;
  logic [5:0]    n_q;
  logic [63:0]   kterm_q;
  logic [39:0]   e_q;
  logic [39:0]   sq_n_q;
  logic [21:0]   sq_rem_q;
  logic [19:0]   root_q;
  logic [27:0]   x_q;
  logic [6:0]    step_q;
  logic [61:0]   mul_a_q;
  logic [61:0]   mul_b_q;
  logic [61:0]   mul_p_q;
  logic          valid_q;
  logic [5:0]    out_idx_q;
  logic [39:0]   out_score_q;
  logic          out_ovf_q;

  logic          accept;
  logic          full;
  logic [24:0]   x_val;
  logic [24:0]   p2;
  logic [24:0]   num;
  logic [25:0]   den;
  div_req_t      div_req;
  logic          div_done;
  logic [63:0]   div_quot;
  logic [62:0]   mul_s;
  logic [61:0]   mul_p_d;
  logic          mul_last;
  logic [23:0]   sq_sh;
  logic [23:0]   sq_trial;
  logic          sq_ge;
  logic [23:0]   sq_sub;
  logic          sq_last;
  logic [63:0]   kprod;
  logic [63:0]   total;
  logic [43:0]   xprod;
  logic [40:0]   score_sum;
  logic [39:0]   score;
  logic [CW+5:0] cnt_ext;

  assign accept  = start_i && !busy_o;
  assign full    = cnt_q >= CW'(MaxChildren);
  assign x_val   = {1'b0, pv_q} + 25'd1;
  assign p2      = 25'd1 << k_q;
  assign num     = x_val - p2;
  assign den     = {1'b0, x_val} + {1'b0, p2};

  assign mul_s    = {1'b0, mul_p_q} + {1'b0, (mul_b_q[0] ? mul_a_q : 62'd0)};
  assign mul_p_d  = mul_s[62:1];
  assign mul_last = step_q == 7'(MUL_STEPS - 1);

  assign sq_sh    = {sq_rem_q, sq_n_q[39:38]};
  assign sq_trial = {2'b00, root_q, 2'b01};
  assign sq_ge    = sq_sh >= sq_trial;
  assign sq_sub   = sq_sh - sq_trial;
  assign sq_last  = step_q == 7'(SQRT_STEPS - 1);

  assign kprod     = {59'd0, k_q} * LN2_Q56;
  assign total     = {5'd0, sum_q[63:5]} + kterm_q;
  assign xprod     = {20'd0, c_q} * {24'd0, root_q};
  assign score_sum = {1'b0, e_q} + {13'd0, x_q};
  assign score     = score_sum[40] ? '1 : score_sum[39:0];
  assign cnt_ext   = {6'd0, cnt_q};

  ucs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (full) begin
            state_d = ST_FINISH;
          end else if (cnt_q == '0) begin
            state_d = ST_LOGNORM;
          end else begin
            state_d = ST_ELAUNCH;
          end
        end
      end
      ST_LOGNORM: if (xn_q[24]) state_d = ST_TDIV;
      ST_TDIV:    if (div_done) state_d = ST_T2MUL;
      ST_T2MUL:   if (mul_last) state_d = ST_SLAUNCH;
      ST_SLAUNCH: state_d = ST_SDIV;
      ST_SDIV: begin
        if (div_done) begin
          state_d = (n_q == 6'(SERIES_TERMS - 1)) ? ST_LNFIN : ST_SMUL;
        end
      end
      ST_SMUL:    if (mul_last) state_d = ST_SLAUNCH;
      ST_LNFIN:   state_d = ST_LNSUM;
      ST_LNSUM:   state_d = ST_ELAUNCH;
      ST_ELAUNCH: state_d = ST_EDIV;
      ST_EDIV:    if (div_done) state_d = ST_QDIV;
      ST_QDIV:    if (div_done) state_d = ST_SQRT;
      ST_SQRT:    if (sq_last) state_d = ST_XMUL;
      ST_XMUL:    state_d = ST_SCORE;
      ST_SCORE:   state_d = ST_FINISH;
      ST_FINISH:  state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Divider requests.
  always_comb begin
    div_req = '0;
    unique case (state_q)
      ST_LOGNORM: begin
        if (xn_q[24]) begin
          div_req.start    = 1'b1;
          div_req.count    = 7'd62;
          div_req.rem_init = {1'b0, num};
          div_req.divisor  = den;
        end
      end
      ST_SLAUNCH: begin
        div_req.start    = 1'b1;
        div_req.count    = 7'd64;
        div_req.divisor  = {19'd0, n_q, 1'b1};
        div_req.dividend = {2'b00, pw_q};
      end
      ST_ELAUNCH: begin
        div_req.start    = 1'b1;
        div_req.count    = 7'd40;
        div_req.divisor  = {1'b0, v1_q};
        div_req.dividend = {wins_q, 40'd0};
      end
      ST_EDIV: begin
        if (div_done) begin
          div_req.start    = 1'b1;
          div_req.count    = 7'd24;
          div_req.divisor  = {1'b0, v1_q};
          div_req.dividend = {log_q, 40'd0};
        end
      end
      default: div_req = '0;
    endcase
  end

  // Control and running set state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      c_q          <= EXPL_RESET;
      cnt_q        <= '0;
      best_score_q <= '0;
      best_idx_q   <= '0;
      ovf_q        <= 1'b0;
      log_q        <= '0;
      step_q       <= '0;
      n_q          <= '0;
      valid_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= 1'b0;
      if (cfg_we_i) begin
        c_q <= cfg_wdata_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept && full) begin
            ovf_q <= 1'b1;
          end
        end
        ST_TDIV: begin
          step_q <= '0;
          n_q    <= '0;
        end
        ST_T2MUL, ST_SMUL, ST_SQRT: begin
          step_q <= step_q + 7'd1;
          if (state_q == ST_SMUL && mul_last) begin
            n_q <= n_q + 6'd1;
          end
        end
        ST_SDIV: step_q <= '0;
        ST_LNSUM: log_q <= total[63:40];
        ST_QDIV: step_q <= '0;
        ST_SCORE: begin
          if (cnt_q == '0 || score > best_score_q) begin
            best_score_q <= score;
            best_idx_q   <= cnt_ext[5:0];
          end
          cnt_q <= cnt_q + CW'(1);
        end
        ST_FINISH: begin
          if (last_q) begin
            valid_q      <= 1'b1;
            cnt_q        <= '0;
            best_score_q <= '0;
            best_idx_q   <= '0;
            ovf_q        <= 1'b0;
            log_q        <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          pv_q   <= parent_visits_i;
          wins_q <= child_wins_i;
          v1_q   <= {1'b0, child_visits_i} + 25'd1;
          last_q <= last_child_i;
          xn_q   <= {1'b0, parent_visits_i} + 25'd1;
          k_q    <= 5'd24;
          sum_q  <= '0;
        end
      end
      ST_LOGNORM: begin
        if (!xn_q[24]) begin
          xn_q <= {xn_q[23:0], 1'b0};
          k_q  <= k_q - 5'd1;
        end
      end
      ST_TDIV: begin
        if (div_done) begin
          pw_q    <= div_quot[61:0];
          mul_a_q <= div_quot[61:0];
          mul_b_q <= div_quot[61:0];
          mul_p_q <= '0;
        end
      end
      ST_T2MUL, ST_SMUL: begin
        mul_p_q <= mul_p_d;
        mul_b_q <= {1'b0, mul_b_q[61:1]};
        if (mul_last) begin
          if (state_q == ST_T2MUL) begin
            t2_q <= mul_p_d;
          end else begin
            pw_q <= mul_p_d;
          end
        end
      end
      ST_SDIV: begin
        if (div_done) begin
          sum_q   <= sum_q + div_quot;
          mul_a_q <= pw_q;
          mul_b_q <= t2_q;
          mul_p_q <= '0;
        end
      end
      ST_LNFIN: kterm_q <= kprod;
      ST_EDIV: if (div_done) e_q <= div_quot[39:0];
      ST_QDIV: begin
        if (div_done) begin
          sq_n_q   <= {div_quot[23:0], 16'd0};
          sq_rem_q <= '0;
          root_q   <= '0;
        end
      end
      ST_SQRT: begin
        sq_n_q   <= {sq_n_q[37:0], 2'b00};
        sq_rem_q <= sq_ge ? sq_sub[21:0] : sq_sh[21:0];
        root_q   <= {root_q[18:0], sq_ge};
      end
      ST_XMUL: x_q <= xprod[43:16];
      ST_FINISH: begin
        out_idx_q   <= best_idx_q;
        out_score_q <= best_score_q;
        out_ovf_q   <= ovf_q;
      end
      default: ;
    endcase
  end

  assign busy_o       = state_q != ST_IDLE;
  assign valid_o      = valid_q;
  assign best_index_o = out_idx_q;
  assign best_score_o = out_score_q;
  assign overflow_o   = out_ovf_q;

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("block not busy after accepting a child");

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(state_q == ST_FINISH && last_q))
    else $error("result without a finished last child");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MaxChildren))
    else $error("child count past its limit");
`endif

endmodule
